// ===== rtl/btt_pkg.sv =====
// shared constants, types and codes for the bucketed transposition table
package btt_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int BUCKET_WAYS   = 4;

    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 16;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 32;

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int WAY_W  = $clog2(BUCKET_WAYS + 1);
    localparam int SUM_W  = $clog2(TABLE_ENTRIES + BUCKET_WAYS);

    localparam bit TBL_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam bit WAY_POW2 = ((BUCKET_WAYS & (BUCKET_WAYS - 1)) == 0);

    typedef enum logic {
        OP_PROBE = 1'b0,
        OP_STORE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        BOUND_NONE  = 2'd0,
        BOUND_EXACT = 2'd1,
        BOUND_UPPER = 2'd2,
        BOUND_LOWER = 2'd3
    } t_bound;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [MOVE_W-1:0]  move;
        logic [DEPTH_W-1:0] depth;
        t_bound             bound;
        logic [SCORE_W-1:0] score;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/bucketed_transposition_table_unit.sv =====
// bucketed transposition table: sequencer, way scan and replacement choice
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  in       | in        | i_in_valid / o_in_ready    | opcode key depth alpha beta score
//           |           |                            | bound_kind move_in
//  out      | out       | o_out_valid / i_out_ready  | cutoff cut_score best_move
//
// each way of the bucket takes a memory read step, then a compare step; an item passes
// through the idle step, the read and compare steps of the ways it scans, and the done step
// every store, whether it finds its key, an empty way or neither, also takes a write step
// table and bucket sizes are powers of two, so the bucket base is a mask of the key
// after reset a clearing pass writes every entry; no input is taken meanwhile
// a finished result waits in the output register; the next item is accepted meanwhile
// and holds in its done step until the register frees
module bucketed_transposition_table_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [btt_pkg::KEY_W-1:0]           i_key,
    input  logic [btt_pkg::DEPTH_W-1:0]         i_depth,
    input  logic signed [btt_pkg::SCORE_W-1:0]  i_alpha,
    input  logic signed [btt_pkg::SCORE_W-1:0]  i_beta,
    input  logic signed [btt_pkg::SCORE_W-1:0]  i_score,
    input  logic [1:0]                          i_bound_kind,
    input  logic [btt_pkg::MOVE_W-1:0]          i_move_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_cutoff,
    output logic signed [btt_pkg::SCORE_W-1:0]  o_cut_score,
    output logic [btt_pkg::MOVE_W-1:0]          o_best_move
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_DONE
    } t_state;

    t_state                              r_state;
    logic [btt_pkg::ADDR_W-1:0]          r_clr_addr;

    btt_pkg::t_opcode                    r_op;
    logic [btt_pkg::KEY_W-1:0]           r_key;
    logic [btt_pkg::DEPTH_W-1:0]         r_depth;
    logic signed [btt_pkg::SCORE_W-1:0]  r_alpha;
    logic signed [btt_pkg::SCORE_W-1:0]  r_beta;
    logic [btt_pkg::SCORE_W-1:0]         r_score;
    btt_pkg::t_bound                     r_bound;
    logic [btt_pkg::MOVE_W-1:0]          r_move;

    logic [btt_pkg::ADDR_W-1:0]          r_base;
    logic [btt_pkg::WAY_W-1:0]           r_way;
    logic [btt_pkg::ADDR_W-1:0]          r_slot;
    logic                                r_have_least;
    logic [btt_pkg::DEPTH_W-1:0]         r_least;

    logic                                r_cut;
    logic signed [btt_pkg::SCORE_W-1:0]  r_res;
    logic [btt_pkg::MOVE_W-1:0]          r_seen;

    logic                                r_out_valid;
    logic                                r_cutoff;
    logic signed [btt_pkg::SCORE_W-1:0]  r_cut_score;
    logic [btt_pkg::MOVE_W-1:0]          r_best_move;

    logic [btt_pkg::ADDR_W-1:0]          w_base;

    logic                                w_we;
    logic [btt_pkg::ADDR_W-1:0]          w_waddr;
    btt_pkg::t_entry                     w_wentry;
    logic [btt_pkg::ADDR_W-1:0]          w_raddr;
    logic [btt_pkg::ENTRY_W-1:0]         w_rdata;
    btt_pkg::t_entry                     w_ent;

    logic                                w_accept;
    logic [btt_pkg::SUM_W-1:0]           w_sum;
    logic                                w_scan_end;
    logic                                w_key_hit;
    logic                                w_deep;
    logic signed [btt_pkg::SCORE_W-1:0]  w_es;
    logic                                w_cut;
    logic signed [btt_pkg::SCORE_W-1:0]  w_cut_val;
    logic                                w_out_free;

    btt_rem_unit u_rem (
        .i_key  (i_key),
        .o_base (w_base)
    );

    btt_ram #(
        .DATA_W (btt_pkg::ENTRY_W),
        .DEPTH  (btt_pkg::TABLE_ENTRIES),
        .ADDR_W (btt_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_sum      = btt_pkg::SUM_W'(r_base) + btt_pkg::SUM_W'(r_way);
        w_scan_end = (r_way == btt_pkg::WAY_W'(btt_pkg::BUCKET_WAYS)) ||
                     (w_sum >= btt_pkg::SUM_W'(btt_pkg::TABLE_ENTRIES));
        w_raddr    = w_sum[btt_pkg::ADDR_W-1:0];
    end

    // one way per check cycle: key compare, depth compare and bound test
    always_comb begin
        w_ent     = btt_pkg::t_entry'(w_rdata);
        w_key_hit = (w_ent.key == r_key);
        w_deep    = (w_ent.depth >= r_depth);
        w_es      = $signed(w_ent.score);
        unique case (w_ent.bound)
            btt_pkg::BOUND_EXACT: begin
                w_cut     = 1'b1;
                w_cut_val = w_es;
            end
            btt_pkg::BOUND_UPPER: begin
                w_cut     = (w_es <= r_alpha);
                w_cut_val = r_alpha;
            end
            btt_pkg::BOUND_LOWER: begin
                w_cut     = (w_es >= r_beta);
                w_cut_val = r_beta;
            end
            btt_pkg::BOUND_NONE: begin
                w_cut     = 1'b0;
                w_cut_val = '0;
            end
        endcase
    end

    always_comb begin
        w_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
        w_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_slot;
        if (r_state == S_CLEAR) begin
            w_wentry = '0;
        end else begin
            w_wentry.key   = r_key;
            w_wentry.move  = r_move;
            w_wentry.depth = r_depth;
            w_wentry.bound = r_bound;
            w_wentry.score = r_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the done step reloads the output register in the same cycle
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == btt_pkg::ADDR_W'(btt_pkg::TABLE_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op         <= btt_pkg::t_opcode'(i_opcode);
                        r_key        <= i_key;
                        r_depth      <= i_depth;
                        r_alpha      <= i_alpha;
                        r_beta       <= i_beta;
                        r_score      <= i_score;
                        r_bound      <= btt_pkg::t_bound'(i_bound_kind);
                        r_move       <= i_move_in;
                        r_base       <= w_base;
                        r_slot       <= w_base;
                        r_cut        <= 1'b0;
                        r_res        <= '0;
                        r_seen       <= '0;
                        r_way        <= '0;
                        r_have_least <= 1'b0;
                        r_state      <= S_READ;
                    end
                end
                S_READ: begin
                    if (w_scan_end) begin
                        r_state <= (r_op == btt_pkg::OP_STORE) ? S_WRITE : S_DONE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_way <= r_way + 1'b1;
                    if (r_op == btt_pkg::OP_PROBE) begin
                        if (w_key_hit) begin
                            r_seen <= w_ent.move;
                        end
                        if (w_key_hit && w_deep && w_cut) begin
                            r_cut   <= 1'b1;
                            r_res   <= w_cut_val;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end else begin
                        if (w_key_hit || (w_ent.key == '0)) begin
                            r_slot  <= w_raddr;
                            r_state <= S_WRITE;
                        end else begin
                            r_state <= S_READ;
                            if (!r_have_least || (w_ent.depth < r_least)) begin
                                r_have_least <= 1'b1;
                                r_least      <= w_ent.depth;
                                r_slot       <= w_raddr;
                            end
                        end
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_cutoff    <= r_cut;
                        r_cut_score <= r_res;
                        r_best_move <= r_seen;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cutoff    = r_cutoff;
    assign o_cut_score = r_cut_score;
    assign o_best_move = r_best_move;

    // a way is only compared after an in-range read
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |->
            ($past(w_sum) < btt_pkg::SUM_W'(btt_pkg::TABLE_ENTRIES)))
        else $error("bucket scan read past the end of the table");

    // stores never report a cutoff or a move
    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_op == btt_pkg::OP_STORE)) |->
            (!r_cut && (r_seen == '0) && (r_res == '0)))
        else $error("store produced a nonzero result");

    // a new result only comes from the done step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result transfer raised outside the done step");

    // table writes only during the clearing pass or the store write step
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_CLEAR) || ((r_state == S_WRITE) && (r_op == btt_pkg::OP_STORE))))
        else $error("table write outside clear or store");

    // the masked bucket base needs power-of-two sizes
    a_pow2_sizes: assert property (@(posedge i_clk)
        btt_pkg::TBL_POW2 && btt_pkg::WAY_POW2)
        else $error("table and bucket sizes must be powers of two");

endmodule

// ===== rtl/btt_ram.sv =====
// single-port-write, registered-read entry memory
module btt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/btt_rem_unit.sv =====
// bucket base from the key: the low key bits with the way bits cleared
module btt_rem_unit (
    input  logic [btt_pkg::KEY_W-1:0]  i_key,
    output logic [btt_pkg::ADDR_W-1:0] o_base
);

    // both sizes are powers of two, so each remainder is a mask
    assign o_base = i_key[btt_pkg::ADDR_W-1:0] &
                    ~btt_pkg::ADDR_W'(btt_pkg::BUCKET_WAYS - 1);

endmodule

// ===== bench/tb.sv =====
// testbench for the bucketed transposition table: directed rows, then random probe and store traffic
module tb;

    localparam int POOL_KEYS    = 24;
    localparam int RANDOM_ITEMS = 825;
    localparam int LONG_HOLD    = 250;

    typedef struct packed {
        btt_pkg::t_opcode            op;
        logic [btt_pkg::KEY_W-1:0]   key;
        logic [btt_pkg::DEPTH_W-1:0] depth;
        logic [btt_pkg::SCORE_W-1:0] alpha;
        logic [btt_pkg::SCORE_W-1:0] beta;
        logic [btt_pkg::SCORE_W-1:0] score;
        btt_pkg::t_bound             bound;
        logic [btt_pkg::MOVE_W-1:0]  move;
    } t_req;

    typedef struct packed {
        logic                        cutoff;
        logic [btt_pkg::SCORE_W-1:0] score;
        logic [btt_pkg::MOVE_W-1:0]  move;
    } t_result;

    typedef struct packed {
        t_req    req;
        logic    typed;
        t_result res;
    } t_dir_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic                                i_opcode;
    logic [btt_pkg::KEY_W-1:0]           i_key;
    logic [btt_pkg::DEPTH_W-1:0]         i_depth;
    logic signed [btt_pkg::SCORE_W-1:0]  i_alpha;
    logic signed [btt_pkg::SCORE_W-1:0]  i_beta;
    logic signed [btt_pkg::SCORE_W-1:0]  i_score;
    logic [1:0]                          i_bound_kind;
    logic [btt_pkg::MOVE_W-1:0]          i_move_in;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic                                o_cutoff;
    logic signed [btt_pkg::SCORE_W-1:0]  o_cut_score;
    logic [btt_pkg::MOVE_W-1:0]          o_best_move;

    // shadow copy of the table
    logic [btt_pkg::KEY_W-1:0]   tt_key   [btt_pkg::TABLE_ENTRIES];
    logic [btt_pkg::MOVE_W-1:0]  tt_move  [btt_pkg::TABLE_ENTRIES];
    logic [btt_pkg::DEPTH_W-1:0] tt_depth [btt_pkg::TABLE_ENTRIES];
    btt_pkg::t_bound             tt_bound [btt_pkg::TABLE_ENTRIES];
    logic [btt_pkg::SCORE_W-1:0] tt_score [btt_pkg::TABLE_ENTRIES];

    t_result                   pending_results [$];
    t_dir_row                  dir_rows [$];
    logic [btt_pkg::KEY_W-1:0] key_pool [POOL_KEYS];
    logic                      quiet = 1'b0;
    int                        results_seen = 0;
    int                        mismatches = 0;

    always #2 i_clk = ~i_clk;

    bucketed_transposition_table_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_key        (i_key),
        .i_depth      (i_depth),
        .i_alpha      (i_alpha),
        .i_beta       (i_beta),
        .i_score      (i_score),
        .i_bound_kind (i_bound_kind),
        .i_move_in    (i_move_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cutoff     (o_cutoff),
        .o_cut_score  (o_cut_score),
        .o_best_move  (o_best_move)
    );

    // applies one probe or store to the shadow table and returns the result it gives
    task automatic table_access(input t_req r, output t_result res);
        logic [63:0]                idx;
        int                         base;
        int                         s;
        int                         slot;
        int                         least;
        logic                       any;
        logic                       hit;
        logic [btt_pkg::MOVE_W-1:0] seen;
        res  = '0;
        idx  = r.key % btt_pkg::TABLE_ENTRIES;
        base = int'(idx - idx % btt_pkg::BUCKET_WAYS);
        if (r.op == btt_pkg::OP_PROBE) begin
            seen = '0;
            hit  = 1'b0;
            for (int w = 0; w < btt_pkg::BUCKET_WAYS && !hit; w++) begin
                s = base + w;
                if (s >= btt_pkg::TABLE_ENTRIES) break;
                if (tt_key[s] == r.key) begin
                    seen = tt_move[s];
                    if (tt_depth[s] >= r.depth) begin
                        case (tt_bound[s])
                            btt_pkg::BOUND_EXACT: begin
                                hit = 1'b1;
                                res.score = tt_score[s];
                            end
                            btt_pkg::BOUND_UPPER:
                                if ($signed(tt_score[s]) <= $signed(r.alpha)) begin
                                    hit = 1'b1;
                                    res.score = r.alpha;
                                end
                            btt_pkg::BOUND_LOWER:
                                if ($signed(tt_score[s]) >= $signed(r.beta)) begin
                                    hit = 1'b1;
                                    res.score = r.beta;
                                end
                            default: ;
                        endcase
                    end
                end
            end
            res.cutoff = hit;
            res.move   = seen;
        end else begin
            slot  = base;
            least = 9999;
            any   = 1'b0;
            for (int w = 0; w < btt_pkg::BUCKET_WAYS; w++) begin
                s = base + w;
                if (s >= btt_pkg::TABLE_ENTRIES) break;
                any = 1'b1;
                if (tt_key[s] == r.key || tt_key[s] == '0) begin
                    slot = s;
                    break;
                end
                // first way of least depth wins ties
                if (int'(tt_depth[s]) < least) begin
                    least = int'(tt_depth[s]);
                    slot  = s;
                end
            end
            if (any && slot < btt_pkg::TABLE_ENTRIES) begin
                tt_key[slot]   = r.key;
                tt_move[slot]  = r.move;
                tt_depth[slot] = r.depth;
                tt_bound[slot] = r.bound;
                tt_score[slot] = r.score;
            end
        end
    endtask

    function automatic int idle_cycles();
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [btt_pkg::SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom;
            default: return int'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    // mostly keys from a few crowded buckets so stores collide and probes hit
    function automatic t_req random_req();
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        r.op = ($urandom_range(0, 99) < 45) ? btt_pkg::OP_STORE : btt_pkg::OP_PROBE;
        if (pick < 3)
            r.key = '0;
        else if (pick < 12)
            r.key = {$urandom, $urandom};
        else
            r.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        pick = $urandom_range(0, 19);
        if (pick == 0)
            r.depth = 8'hFF;
        else if (pick < 4)
            r.depth = btt_pkg::DEPTH_W'($urandom);
        else
            r.depth = btt_pkg::DEPTH_W'($urandom_range(0, 12));
        r.alpha = pick_score();
        r.beta  = pick_score();
        r.score = pick_score();
        r.bound = btt_pkg::t_bound'($urandom_range(0, 3));
        r.move  = btt_pkg::MOVE_W'($urandom);
        return r;
    endfunction

    task automatic probe_row(input logic [btt_pkg::KEY_W-1:0] key,
                             input logic [btt_pkg::DEPTH_W-1:0] depth,
                             input logic [btt_pkg::SCORE_W-1:0] alpha,
                             input logic [btt_pkg::SCORE_W-1:0] beta,
                             input logic typed, input logic cut,
                             input logic [btt_pkg::SCORE_W-1:0] score,
                             input logic [btt_pkg::MOVE_W-1:0] move);
        t_dir_row row;
        row.req.op    = btt_pkg::OP_PROBE;
        row.req.key   = key;
        row.req.depth = depth;
        row.req.alpha = alpha;
        row.req.beta  = beta;
        row.req.score = $urandom;
        row.req.bound = btt_pkg::t_bound'($urandom_range(0, 3));
        row.req.move  = btt_pkg::MOVE_W'($urandom);
        row.typed     = typed;
        row.res       = {cut, score, move};
        dir_rows.push_back(row);
    endtask

    task automatic store_row(input logic [btt_pkg::KEY_W-1:0] key,
                             input logic [btt_pkg::DEPTH_W-1:0] depth,
                             input logic [btt_pkg::SCORE_W-1:0] score,
                             input btt_pkg::t_bound bound,
                             input logic [btt_pkg::MOVE_W-1:0] move);
        t_dir_row row;
        row.req.op    = btt_pkg::OP_STORE;
        row.req.key   = key;
        row.req.depth = depth;
        row.req.alpha = $urandom;
        row.req.beta  = $urandom;
        row.req.score = score;
        row.req.bound = bound;
        row.req.move  = move;
        row.typed     = 1'b1;
        row.res       = '0;
        dir_rows.push_back(row);
    endtask

    // one input transfer, entered and left at a falling edge
    task automatic offer(input t_req r, input logic typed, input t_result typed_res);
        int      gap;
        t_result want;
        gap = idle_cycles();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode     <= r.op;
        i_key        <= r.key;
        i_depth      <= r.depth;
        i_alpha      <= r.alpha;
        i_beta       <= r.beta;
        i_score      <= r.score;
        i_bound_kind <= r.bound;
        i_move_in    <= r.move;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        table_access(r, want);
        pending_results.push_back(typed ? typed_res : want);
        @(negedge i_clk);
    endtask

    initial begin
        logic [7:0]                grp [4];
        logic [btt_pkg::KEY_W-1:0] k;
        t_result                   none;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = 1'b0;
        i_key        = '0;
        i_depth      = '0;
        i_alpha      = '0;
        i_beta       = '0;
        i_score      = '0;
        i_bound_kind = '0;
        i_move_in    = '0;
        i_out_ready  = 1'b0;
        none         = '0;
        for (int i = 0; i < btt_pkg::TABLE_ENTRIES; i++) begin
            tt_key[i]   = '0;
            tt_move[i]  = '0;
            tt_depth[i] = '0;
            tt_bound[i] = btt_pkg::BOUND_NONE;
            tt_score[i] = '0;
        end

        // empty table: key zero matches empty ways but they never cut
        probe_row(64'h0, 8'd0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0, 16'h0);
        probe_row(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  1'b1, 1'b0, 32'h0, 16'h0);
        store_row(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'h7FFF_FFFF, btt_pkg::BOUND_EXACT,
                  16'hFFFF);
        probe_row(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'h0, 32'h0,
                  1'b1, 1'b1, 32'h7FFF_FFFF, 16'hFFFF);
        // one bucket filled with upper, lower, none and exact entries
        store_row(64'h0123_4567_89AB_C2A0, 8'd5, -32'sd100, btt_pkg::BOUND_UPPER, 16'h0101);
        probe_row(64'h0123_4567_89AB_C2A0, 8'd5, -32'sd100, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        probe_row(64'h0123_4567_89AB_C2A0, 8'd5, -32'sd101, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        probe_row(64'h0123_4567_89AB_C2A0, 8'd6, -32'sd100, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        store_row(64'hFEDC_BA98_7654_32A1, 8'd7, 32'sd300, btt_pkg::BOUND_LOWER, 16'h0202);
        probe_row(64'hFEDC_BA98_7654_32A1, 8'd7, 32'h0, 32'sd300, 1'b0, 1'b0, 32'h0, 16'h0);
        store_row(64'h0F0F_0F0F_0F0F_02A2, 8'd9, 32'sd5, btt_pkg::BOUND_NONE, 16'h0303);
        probe_row(64'h0F0F_0F0F_0F0F_02A2, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                  1'b0, 1'b0, 32'h0, 16'h0);
        // an exact entry with a large negative score still cuts
        store_row(64'hA5A5_5A5A_A5A5_5EA3, 8'd0, -32'sd50001, btt_pkg::BOUND_EXACT, 16'h0404);
        probe_row(64'hA5A5_5A5A_A5A5_5EA3, 8'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        // bucket full: evicts the shallowest way
        store_row(64'h5555_AAAA_0000_06A0, 8'd3, 32'sd42, btt_pkg::BOUND_EXACT, 16'h0505);
        probe_row(64'hA5A5_5A5A_A5A5_5EA3, 8'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        probe_row(64'h5555_AAAA_0000_06A0, 8'd3, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        store_row(64'h0, 8'd1, 32'sd7, btt_pkg::BOUND_EXACT, 16'h0707);
        probe_row(64'h0, 8'd0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0);
        store_row(64'h8000_0000_0000_0100, 8'hFF, 32'h8000_0000, btt_pkg::BOUND_UPPER,
                  16'h0000);
        probe_row(64'h8000_0000_0000_0100, 8'hFF, 32'h8000_0000, 32'h0,
                  1'b1, 1'b1, 32'h8000_0000, 16'h0000);
        store_row(64'h7FFF_FFFF_FFFF_FE04, 8'd128, 32'h7FFF_FFFF, btt_pkg::BOUND_LOWER,
                  16'h1234);
        probe_row(64'h7FFF_FFFF_FFFF_FE04, 8'd128, 32'h0, 32'h7FFF_FFFF,
                  1'b1, 1'b1, 32'h7FFF_FFFF, 16'h1234);
        // overwrite of a present key lands in its own way
        store_row(64'h0123_4567_89AB_C2A0, 8'd2, 32'sd11, btt_pkg::BOUND_EXACT, 16'h0111);
        probe_row(64'h0123_4567_89AB_C2A0, 8'd2, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 16'h0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = ((n / 100) % 4 == 3);
            if (n % 200 == 0) begin
                grp[0] = 8'h00;
                grp[1] = 8'hFF;
                grp[2] = 8'($urandom);
                grp[3] = 8'($urandom);
                for (int i = 0; i < POOL_KEYS; i++) begin
                    k = {$urandom, $urandom};
                    k[9:2] = grp[i / 6];
                    key_pool[i] = k;
                end
            end
            offer(random_req(), 1'b0, none);
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // result side: random stalls, one long hold-off to back the block up
    initial begin
        int      hold;
        t_result want;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = (results_seen == 400) ? LONG_HOLD : idle_cycles();
            if (hold != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cutoff %0d score %0d move %h",
                             o_cutoff, o_cut_score, o_best_move);
            end else begin
                want = pending_results.pop_front();
                if (o_cutoff !== want.cutoff || o_cut_score !== want.score
                        || o_best_move !== want.move) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: got cutoff %0d score %0d move %h, want %0d %0d %h",
                                 results_seen, o_cutoff, o_cut_score, o_best_move,
                                 want.cutoff, $signed(want.score), want.move);
                end
            end
            results_seen++;
            @(negedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
